>>> src/tewu_pkg.sv
// Shared types and constants for the TSP edge weight unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package tewu_pkg;

   // Default geometry of the coordinate fields
   localparam int DEF_COORD_WIDTH = 24;
   localparam int DEF_FRAC_BITS   = 8;

   // Result field
   localparam int                     EDGE_WIDTH = 17;
   localparam logic [EDGE_WIDTH-1:0]  EDGE_MAX   = 17'h1FFFF;

   // Configuration register
   localparam int               CSR_WIDTH = 2;
   localparam logic [CSR_WIDTH-1:0] CSR_RESET = 2'd0;

   // Pipeline depth outside the root stages
   localparam int FRONT_LATENCY = 5;
   localparam int BACK_LATENCY  = 2;

   // Distance kinds; the reserved code is captured as is and runs as the rounded kind
   typedef enum logic [CSR_WIDTH-1:0] {
      KIND_EUC  = 2'd0,
      KIND_CEIL = 2'd1,
      KIND_ATT  = 2'd2
   } kind_type;

   // Control that travels with each item down the pipeline
   typedef struct packed {
      logic     valid;
      kind_type kind;
      logic     zero;   // squared length was zero
   } tewu_ctl_type;

endpackage

`default_nettype wire

>>> src/tsp_edge_weight_unit_core.sv
// Top level of the TSP edge weight unit: command port, distance kind register, pipeline.
// Depends on tewu_pkg, tewu_front, tewu_root_stage and tewu_back.
//
//   channel    ports                                   transfer when
//   request    start, busy, req_x/y_first/second       start && !busy
//   response   rsp_valid, rsp_edge_weight              rsp_valid (one cycle strobe)
//   register   csr_valid, csr_ready, csr_wdata         csr_valid && csr_ready
//
// One point pair may enter every cycle in which busy is low. Each result passes the
// front end, then the square root, which resolves one result bit per pipeline stage,
// then the back end. busy is high only in the cycle after a reset cycle; the pipeline
// never stalls, as the response side has no back-pressure. Reset clears the valid bits
// and the kind.
`default_nettype none

module tsp_edge_weight_unit_core import tewu_pkg::*; #(
   parameter int COORD_FRAC_BITS = DEF_FRAC_BITS,
   parameter int COORD_WIDTH     = DEF_COORD_WIDTH
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic [COORD_WIDTH-1:0] req_x_first,
   input  wire logic [COORD_WIDTH-1:0] req_y_first,
   input  wire logic [COORD_WIDTH-1:0] req_x_second,
   input  wire logic [COORD_WIDTH-1:0] req_y_second,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_WIDTH-1:0]   csr_wdata,
   output logic                        rsp_valid,
   output logic [EDGE_WIDTH-1:0]       rsp_edge_weight
);

   localparam int OPW     = 2*COORD_WIDTH + 3;
   localparam int RB      = COORD_WIDTH + 2;
   localparam int LATENCY = FRONT_LATENCY + RB + BACK_LATENCY;

   logic [CSR_WIDTH-1:0] csr_ff;
   logic                 busy_ff;
   tewu_ctl_type         ctl_req;
   kind_type             kind_sel;

   tewu_ctl_type         ctl_chain  [RB+1];
   logic [OPW-1:0]       rem_chain  [RB+1];
   logic [RB-1:0]        root_chain [RB+1];

   // Distance kind register and reset-time busy
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff  <= CSR_RESET;
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
         if (csr_valid) begin
            csr_ff <= csr_wdata;
         end
      end
   end

   assign csr_ready = 1'b1;
   assign busy      = busy_ff;

   // Reserved code runs as the rounded kind
   always_comb begin
      case (csr_ff)
         KIND_CEIL: kind_sel = KIND_CEIL;
         KIND_ATT:  kind_sel = KIND_ATT;
         default:   kind_sel = KIND_EUC;
      endcase
      ctl_req.valid = start && !busy_ff;
      ctl_req.kind  = kind_sel;
      ctl_req.zero  = 1'b0;
   end

   tewu_front #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .ctl_up   (ctl_req),
      .x_first  (req_x_first),
      .y_first  (req_y_first),
      .x_second (req_x_second),
      .y_second (req_y_second),
      .ctl_dn   (ctl_chain[0]),
      .operand  (rem_chain[0])
   );

   assign root_chain[0] = '0;

   // Square root, most significant result bit first
   for (genvar k = 0; k < RB; k++) begin : g_root
      tewu_root_stage #(
         .COORD_WIDTH (COORD_WIDTH),
         .FRAC_BITS   (COORD_FRAC_BITS),
         .BIT_POS     (RB - 1 - k)
      ) u_stage (
         .clock   (clock),
         .reset   (reset),
         .ctl_up  (ctl_chain[k]),
         .rem_up  (rem_chain[k]),
         .root_up (root_chain[k]),
         .ctl_dn  (ctl_chain[k+1]),
         .rem_dn  (rem_chain[k+1]),
         .root_dn (root_chain[k+1])
      );
   end

   tewu_back #(
      .COORD_WIDTH (COORD_WIDTH),
      .FRAC_BITS   (COORD_FRAC_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .ctl_up          (ctl_chain[RB]),
      .rem_up          (rem_chain[RB]),
      .root_up         (root_chain[RB]),
      .rsp_valid       (rsp_valid),
      .rsp_edge_weight (rsp_edge_weight)
   );

`ifndef ASSERT_OFF
   // every request transfer gives a result after the fixed latency
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("request transfer without response");

   // no response without a matching request transfer
   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("response without request");

   // identical points give a zero weight under every kind
   a_same_point: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(req_x_first == req_x_second && req_y_first == req_y_second,
                          LATENCY)) |-> (rsp_edge_weight == '0))
      else $error("non-zero weight for identical points");
`endif

endmodule

`default_nettype wire

>>> src/tewu_front.sv
// Front end: coordinate differences, magnitudes, squares, squared length and root operand.
// Depends on tewu_pkg.
`default_nettype none

module tewu_front import tewu_pkg::*; #(
   parameter  int COORD_WIDTH = DEF_COORD_WIDTH,
   localparam int OPW         = 2*COORD_WIDTH + 3
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire tewu_ctl_type            ctl_up,
   input  wire logic [COORD_WIDTH-1:0]  x_first,
   input  wire logic [COORD_WIDTH-1:0]  y_first,
   input  wire logic [COORD_WIDTH-1:0]  x_second,
   input  wire logic [COORD_WIDTH-1:0]  y_second,
   output tewu_ctl_type                 ctl_dn,
   output logic [OPW-1:0]               operand
);

   localparam int SQW = 2*COORD_WIDTH;

   tewu_ctl_type ctl1_ff, ctl2_ff, ctl3_ff, ctl4_ff, ctl5_ff;
   tewu_ctl_type ctl1_in, ctl5_in;

   logic [COORD_WIDTH:0]   dx_in, dy_in, dx_ff, dy_ff;
   logic [COORD_WIDTH-1:0] dxm_in, dym_in, dxm_ff, dym_ff;
   logic [SQW-1:0]         dxs_in, dys_in, dxs_ff, dys_ff;
   logic [SQW:0]           sum_in, sum_ff;
   logic [OPW-1:0]         operand_in, operand_ff;
   logic                   zero_len;

   // Stage 1: sign-extended differences
   always_comb begin
      dx_in   = {x_first[COORD_WIDTH-1], x_first} - {x_second[COORD_WIDTH-1], x_second};
      dy_in   = {y_first[COORD_WIDTH-1], y_first} - {y_second[COORD_WIDTH-1], y_second};
      ctl1_in = ctl_up;
      ctl1_in.zero = 1'b0;
   end

   // Stage 2: magnitudes, always below 2^COORD_WIDTH
   always_comb begin
      dxm_in = dx_ff[COORD_WIDTH] ? COORD_WIDTH'(~dx_ff + 1'b1) : dx_ff[COORD_WIDTH-1:0];
      dym_in = dy_ff[COORD_WIDTH] ? COORD_WIDTH'(~dy_ff + 1'b1) : dy_ff[COORD_WIDTH-1:0];
   end

   // Stage 3: squares
   always_comb begin
      dxs_in = SQW'(dxm_ff) * SQW'(dxm_ff);
      dys_in = SQW'(dym_ff) * SQW'(dym_ff);
   end

   // Stage 4: squared length
   assign sum_in = (SQW+1)'(dxs_ff) + (SQW+1)'(dys_ff);

   // Stage 5: root operand per kind
   // rounded: 4s; ceiling: s; ATT: s-1 (the scaled compare sits in the root stages)
   always_comb begin
      zero_len = (sum_ff == '0);
      ctl5_in  = ctl4_ff;
      ctl5_in.zero = zero_len;
      case (ctl4_ff.kind)
         KIND_EUC:  operand_in = {sum_ff, 2'b00};
         KIND_CEIL: operand_in = OPW'(sum_ff);
         KIND_ATT:  operand_in = zero_len ? '0 : OPW'(sum_ff) - OPW'(1);
         default:   operand_in = {sum_ff, 2'b00};
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
         ctl3_ff <= '0;
         ctl4_ff <= '0;
         ctl5_ff <= '0;
      end else begin
         ctl1_ff <= ctl1_in;
         ctl2_ff <= ctl1_ff;
         ctl3_ff <= ctl2_ff;
         ctl4_ff <= ctl3_ff;
         ctl5_ff <= ctl5_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      dx_ff      <= dx_in;
      dy_ff      <= dy_in;
      dxm_ff     <= dxm_in;
      dym_ff     <= dym_in;
      dxs_ff     <= dxs_in;
      dys_ff     <= dys_in;
      sum_ff     <= sum_in;
      operand_ff <= operand_in;
   end

   assign ctl_dn  = ctl5_ff;
   assign operand = operand_ff;

endmodule

`default_nettype wire

>>> src/tewu_root_stage.sv
// One bit of the pipelined restoring square root, with the ATT scaled compare.
// Depends on tewu_pkg.
`default_nettype none

module tewu_root_stage import tewu_pkg::*; #(
   parameter  int COORD_WIDTH = DEF_COORD_WIDTH,
   parameter  int FRAC_BITS   = DEF_FRAC_BITS,
   parameter  int BIT_POS     = 0,
   localparam int OPW         = 2*COORD_WIDTH + 3,
   localparam int RB          = COORD_WIDTH + 2
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire tewu_ctl_type  ctl_up,
   input  wire logic [OPW-1:0] rem_up,
   input  wire logic [RB-1:0] root_up,
   output tewu_ctl_type       ctl_dn,
   output logic [OPW-1:0]     rem_dn,
   output logic [RB-1:0]      root_dn
);

   // room for the trial term scaled by 10 * 2^(2*FRAC_BITS)
   localparam int DW = OPW + 5 + 2*FRAC_BITS;

   tewu_ctl_type   ctl_ff;
   logic [OPW-1:0] rem_in, rem_ff;
   logic [RB-1:0]  root_in, root_ff;
   logic [DW-1:0]  rem_ext, d_base, d_att, trial, diff;
   logic           fits;

   // trial: (root + b)^2 - root^2 = 2*root*b + b^2, with b = 2^BIT_POS
   // root has no bits at or below BIT_POS, so the two terms do not overlap
   always_comb begin
      rem_ext = DW'(rem_up);
      d_base  = (DW'(root_up) << (BIT_POS + 1)) | (DW'(1) << (2*BIT_POS));
      d_att   = (d_base << (2*FRAC_BITS + 3)) + (d_base << (2*FRAC_BITS + 1));
      trial   = (ctl_up.kind == KIND_ATT) ? d_att : d_base;
      fits    = (rem_ext >= trial);
      diff    = rem_ext - trial;
      rem_in  = fits ? OPW'(diff) : rem_up;
      root_in = fits ? (root_up | (RB'(1) << BIT_POS)) : root_up;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_up;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign ctl_dn  = ctl_ff;
   assign rem_dn  = rem_ff;
   assign root_dn = root_ff;

endmodule

`default_nettype wire

>>> src/tewu_back.sv
// Back end: rounding or ceiling of the root per kind, then saturation to the result width.
// Depends on tewu_pkg.
`default_nettype none

module tewu_back import tewu_pkg::*; #(
   parameter  int COORD_WIDTH = DEF_COORD_WIDTH,
   parameter  int FRAC_BITS   = DEF_FRAC_BITS,
   localparam int OPW         = 2*COORD_WIDTH + 3,
   localparam int RB          = COORD_WIDTH + 2
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire tewu_ctl_type    ctl_up,
   input  wire logic [OPW-1:0]  rem_up,
   input  wire logic [RB-1:0]   root_up,
   output logic                 rsp_valid,
   output logic [EDGE_WIDTH-1:0] rsp_edge_weight
);

   localparam int TW = ((RB > FRAC_BITS) ? RB : FRAC_BITS) + 2;
   localparam int WW = (TW > EDGE_WIDTH) ? TW : EDGE_WIDTH;

   logic                  valid1_ff, valid2_ff;
   logic [TW-1:0]         t, m, w_in, w_ff;
   logic                  exact;
   logic [EDGE_WIDTH-1:0] weight_in, weight_ff;

   // Stage 1: integer weight from the root
   always_comb begin
      t     = TW'(root_up);
      m     = TW'(1) << FRAC_BITS;
      exact = (rem_up == '0);
      case (ctl_up.kind)
         KIND_EUC:  w_in = (t + m) >> (FRAC_BITS + 1);
         KIND_CEIL: w_in = exact ? ((t + m - TW'(1)) >> FRAC_BITS)
                                 : ((t >> FRAC_BITS) + TW'(1));
         KIND_ATT:  w_in = ctl_up.zero ? '0 : t + TW'(1);
         default:   w_in = (t + m) >> (FRAC_BITS + 1);
      endcase
   end

   // Stage 2: saturate
   assign weight_in = (WW'(w_ff) > WW'(EDGE_MAX)) ? EDGE_MAX : EDGE_WIDTH'(WW'(w_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else begin
         valid1_ff <= ctl_up.valid;
         valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      w_ff      <= w_in;
      weight_ff <= weight_in;
   end

   assign rsp_valid       = valid2_ff;
   assign rsp_edge_weight = weight_ff;

endmodule

`default_nettype wire
